@@ rtl/rpy_pkg.sv @@
// shared types, constants and tables for the rpy angles to rotation matrix block
package rpy_pkg;

	localparam int OUT_FRAC_BITS   = 14;
	localparam int TRIG_ITERATIONS = 16;

	localparam int ANGLE_W = 15;
	localparam int ENTRY_W = 16;
	localparam int CW      = 34;

	typedef logic signed [ANGLE_W-1:0] angle_t;
	typedef logic signed [ENTRY_W-1:0] entry_t;
	typedef logic signed [CW-1:0]      cval_t;
	typedef logic signed [31:0]        q30_t;
	typedef logic signed [63:0]        q60_t;

	// degrees*64 to binary angle: d*2^23/45 = d*HI_MUL + (23*d)/45
	localparam logic [17:0] HI_MUL  = 18'd186413;
	localparam logic [24:0] RECIP45 = 25'd23860930;

	localparam q30_t CORDIC_GAIN = 32'sd652032874;

	localparam q30_t ATAN_BAM [32] = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
		32'sd42667331, 32'sd21354465, 32'sd10679838, 32'sd5340245,
		32'sd2670163, 32'sd1335087, 32'sd667544, 32'sd333772,
		32'sd166886, 32'sd83443, 32'sd41722, 32'sd20861,
		32'sd10430, 32'sd5215, 32'sd2608, 32'sd1304,
		32'sd652, 32'sd326, 32'sd163, 32'sd81,
		32'sd41, 32'sd20, 32'sd10, 32'sd5,
		32'sd3, 32'sd1, 32'sd1, 32'sd0
	};

endpackage

@@ rtl/rpy_in_if.sv @@
// angle triple channel
interface rpy_in_if;
	import rpy_pkg::*;

	logic   valid;
	logic   ready;
	angle_t angle_x;
	angle_t angle_y;
	angle_t angle_z;

	modport source (output valid, angle_x, angle_y, angle_z, input ready);
	modport sink (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

@@ rtl/rpy_out_if.sv @@
// rotation matrix channel
interface rpy_out_if;
	import rpy_pkg::*;

	logic   valid;
	logic   ready;
	entry_t m00, m01, m02, m10, m11, m12, m20, m21, m22;

	modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		input ready);
	modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		output ready);
endinterface

@@ rtl/rpy_angles_to_rotation_matrix.sv @@
// roll/pitch/yaw angles to rotation matrix Rz*Ry*Rx, fully pipelined
// one cordic step per stage, between the angle fold stage and the sine/cosine unfold stage
// throughput: one beat per cycle; each stage holds only while the stage after it is full
// and stalled, so bubbles collapse and a stalled output still lets earlier stages fill
// reset: arst_n clears the valid bits only, data registers keep whatever they hold
module rpy_angles_to_rotation_matrix (
	input  logic clk,
	input  logic arst_n,
	rpy_in_if.sink    angles,
	rpy_out_if.source matrix
);
	import rpy_pkg::*;

	localparam int N         = TRIG_ITERATIONS;
	localparam int ST_CONV   = 0;
	localparam int ST_FOLD   = 1;
	localparam int ST_CORDIC = 2;
	localparam int ST_TRIG   = ST_CORDIC + N;
	localparam int ST_PROD   = ST_TRIG + 1;
	localparam int ST_MUL3   = ST_PROD + 1;
	localparam int ST_SUM    = ST_MUL3 + 1;
	localparam int ST_OUT    = ST_SUM + 1;
	localparam int NST       = ST_OUT + 1;
	localparam int SH        = 60 - OUT_FRAC_BITS;
	localparam q60_t RND     = q60_t'(1) <<< (SH - 1);
	localparam q60_t ONE     = q60_t'(1) <<< OUT_FRAC_BITS;

	// valid bit per stage and a per-stage load enable
	logic [NST-1:0] vld_q;
	logic [NST:0]   en;

	// enable ripples back from the output, last stage first
	always_comb begin
		en[NST] = matrix.ready;
		for (int k = NST - 1; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end
	assign angles.ready = en[ST_CONV];
	assign matrix.valid = vld_q[ST_OUT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= angles.valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// angle order inside arrays: 0 roll (x), 1 pitch (y), 2 yaw (z)
	angle_t ang [3];
	assign ang[0] = angles.angle_x;
	assign ang[1] = angles.angle_y;
	assign ang[2] = angles.angle_z;

	// stage 1: magnitude times 2^23/45, split into integer part and remainder part
	logic [14:0] mag  [3];
	logic [18:0] rem  [3];
	logic [32:0] hi_s1 [3];
	logic [43:0] lo_s1 [3];
	logic        neg_s1 [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			mag[j] = ang[j][ANGLE_W-1] ? 15'(-ang[j]) : 15'(ang[j]);
			rem[j] = 19'(mag[j]) * 19'd23 + 19'd22;
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_CONV]) begin
			for (int j = 0; j < 3; j++) begin
				hi_s1[j]  <= 33'(mag[j]) * 33'(HI_MUL);
				lo_s1[j]  <= 44'(rem[j]) * 44'(RECIP45);
				neg_s1[j] <= ang[j][ANGLE_W-1];
			end
		end
	end

	// stage 2: round-half-away magnitude, apply sign, wrap to a turn, fold quadrants 2 and 3
	logic [33:0] amag [3];
	logic [33:0] asgn [3];
	logic [31:0] bam  [3];
	logic        qflip [3];
	cval_t       z_s2 [3];
	logic        flip_s2 [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			amag[j]  = 34'(hi_s1[j]) + 34'(lo_s1[j][43:30]);
			asgn[j]  = neg_s1[j] ? -amag[j] : amag[j];
			bam[j]   = asgn[j][31:0];
			qflip[j] = bam[j][31] ^ bam[j][30];
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_FOLD]) begin
			for (int j = 0; j < 3; j++) begin
				z_s2[j]    <= CW'($signed({bam[j][31] ^ qflip[j], bam[j][30:0]}));
				flip_s2[j] <= qflip[j];
			end
		end
	end

	// cordic: one rotation step per stage, three angles side by side
	cval_t cx_s3 [N][3];
	cval_t cy_s3 [N][3];
	cval_t cz_s3 [N][3];
	logic  cf_s3 [N][3];

	for (genvar k = 0; k < N; k++) begin : g_cordic
		cval_t xin [3];
		cval_t yin [3];
		cval_t zin [3];
		logic  fin [3];
		cval_t atk;

		assign atk = CW'(ATAN_BAM[k]);

		if (k == 0) begin : g_first
			always_comb begin
				for (int j = 0; j < 3; j++) begin
					xin[j] = CW'(CORDIC_GAIN);
					yin[j] = '0;
					zin[j] = z_s2[j];
					fin[j] = flip_s2[j];
				end
			end
		end else begin : g_next
			always_comb begin
				for (int j = 0; j < 3; j++) begin
					xin[j] = cx_s3[k-1][j];
					yin[j] = cy_s3[k-1][j];
					zin[j] = cz_s3[k-1][j];
					fin[j] = cf_s3[k-1][j];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[ST_CORDIC+k]) begin
				for (int j = 0; j < 3; j++) begin
					if (!zin[j][CW-1]) begin
						cx_s3[k][j] <= xin[j] - (yin[j] >>> k);
						cy_s3[k][j] <= yin[j] + (xin[j] >>> k);
						cz_s3[k][j] <= zin[j] - atk;
					end else begin
						cx_s3[k][j] <= xin[j] + (yin[j] >>> k);
						cy_s3[k][j] <= yin[j] - (xin[j] >>> k);
						cz_s3[k][j] <= zin[j] + atk;
					end
					cf_s3[k][j] <= fin[j];
				end
			end
		end
	end

	// unfold quadrant: negate both sine and cosine
	q30_t cos_s4 [3];
	q30_t sin_s4 [3];

	always_ff @(posedge clk) begin
		if (en[ST_TRIG]) begin
			for (int j = 0; j < 3; j++) begin
				cos_s4[j] <= 32'(cf_s3[N-1][j] ? -cx_s3[N-1][j] : cx_s3[N-1][j]);
				sin_s4[j] <= 32'(cf_s3[N-1][j] ? -cy_s3[N-1][j] : cy_s3[N-1][j]);
			end
		end
	end

	// two-factor products, Q60
	q60_t cacb_s5, sacg_s5, sasg_s5, sacb_s5, cacg_s5, casg_s5, cbsg_s5, cbcg_s5;
	q60_t casb_s5, sasb_s5;
	q30_t sb_s5, sg_s5, cg_s5;

	always_ff @(posedge clk) begin
		if (en[ST_PROD]) begin
			cacb_s5 <= cos_s4[2] * cos_s4[1];
			sacg_s5 <= sin_s4[2] * cos_s4[0];
			sasg_s5 <= sin_s4[2] * sin_s4[0];
			sacb_s5 <= sin_s4[2] * cos_s4[1];
			cacg_s5 <= cos_s4[2] * cos_s4[0];
			casg_s5 <= cos_s4[2] * sin_s4[0];
			cbsg_s5 <= cos_s4[1] * sin_s4[0];
			cbcg_s5 <= cos_s4[1] * cos_s4[0];
			casb_s5 <= cos_s4[2] * sin_s4[1];
			sasb_s5 <= sin_s4[2] * sin_s4[1];
			sb_s5   <= sin_s4[1];
			sg_s5   <= sin_s4[0];
			cg_s5   <= cos_s4[0];
		end
	end

	// three-factor products: round the first pair back to Q30, then the third factor
	logic signed [33:0] casb_r, sasb_r;
	q60_t t1_s6, t2_s6, t3_s6, t4_s6;
	q60_t cacb_s6, sacg_s6, sasg_s6, sacb_s6, cacg_s6, casg_s6, cbsg_s6, cbcg_s6;
	q30_t sb_s6;

	assign casb_r = 34'((casb_s5 + (q60_t'(1) <<< 29)) >>> 30);
	assign sasb_r = 34'((sasb_s5 + (q60_t'(1) <<< 29)) >>> 30);

	always_ff @(posedge clk) begin
		if (en[ST_MUL3]) begin
			t1_s6   <= casb_r * sg_s5;
			t2_s6   <= casb_r * cg_s5;
			t3_s6   <= sasb_r * sg_s5;
			t4_s6   <= sasb_r * cg_s5;
			cacb_s6 <= cacb_s5;
			sacg_s6 <= sacg_s5;
			sasg_s6 <= sasg_s5;
			sacb_s6 <= sacb_s5;
			cacg_s6 <= cacg_s5;
			casg_s6 <= casg_s5;
			cbsg_s6 <= cbsg_s5;
			cbcg_s6 <= cbcg_s5;
			sb_s6   <= sb_s5;
		end
	end

	// matrix entries in Q60, row major
	q60_t sum_s7 [9];

	always_ff @(posedge clk) begin
		if (en[ST_SUM]) begin
			sum_s7[0] <= cacb_s6;
			sum_s7[1] <= t1_s6 - sacg_s6;
			sum_s7[2] <= t2_s6 + sasg_s6;
			sum_s7[3] <= sacb_s6;
			sum_s7[4] <= t3_s6 + cacg_s6;
			sum_s7[5] <= t4_s6 - casg_s6;
			sum_s7[6] <= -(q60_t'(sb_s6) <<< 30);
			sum_s7[7] <= cbsg_s6;
			sum_s7[8] <= cbcg_s6;
		end
	end

	// round to the output format and clamp rounding overshoot to plus or minus one
	q60_t   rnd [9];
	entry_t out_s8 [9];

	always_comb begin
		for (int j = 0; j < 9; j++) begin
			rnd[j] = (sum_s7[j] + RND) >>> SH;
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_OUT]) begin
			for (int j = 0; j < 9; j++) begin
				if (rnd[j] > ONE) begin
					out_s8[j] <= ENTRY_W'(ONE);
				end else if (rnd[j] < -ONE) begin
					out_s8[j] <= ENTRY_W'(-ONE);
				end else begin
					out_s8[j] <= ENTRY_W'(rnd[j]);
				end
			end
		end
	end

	assign matrix.m00 = out_s8[0];
	assign matrix.m01 = out_s8[1];
	assign matrix.m02 = out_s8[2];
	assign matrix.m10 = out_s8[3];
	assign matrix.m11 = out_s8[4];
	assign matrix.m12 = out_s8[5];
	assign matrix.m20 = out_s8[6];
	assign matrix.m21 = out_s8[7];
	assign matrix.m22 = out_s8[8];

	// a full pipeline with a stalled output must refuse new beats
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(&vld_q && !matrix.ready) |-> !angles.ready)
		else $error("input accepted while pipeline full and stalled");

	// an empty pipeline always takes a beat
	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!(|vld_q) |-> angles.ready)
		else $error("empty pipeline not ready");

	// an accepted beat lands in the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(angles.valid && angles.ready) |=> vld_q[ST_CONV])
		else $error("accepted beat lost at entry");

	// a stalled result is not overwritten
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(matrix.valid && !matrix.ready) |=> (matrix.valid && $stable(out_s8[4])))
		else $error("stalled result changed");

endmodule

@@ dv/tb_rpy_angles_to_rotation_matrix.sv @@
// testbench for the rpy angles to rotation matrix block: random and directed angle triples
`timescale 1ns / 1ps

import rpy_pkg::*;

// matrix entries expected for each accepted angle triple, in arrival order
typedef struct {
	entry_t m [9];
} rot_matrix_t;

class rotation_scoreboard;
	rot_matrix_t pending [$];
	int errors;

	// floor shift on 64-bit signed values (>>> is arithmetic, so it floors)
	static function longint fshift(longint v, int s);
		return v >>> s;
	endfunction

	// sine and cosine in Q2.30 from a degrees*64 angle
	static function void sin_cos(angle_t ang, output longint s, output longint c);
		longint deg, num, a, x, y, z, dx, dy;
		bit [31:0] u;
		bit flip;
		deg = longint'(ang);
		num = deg * 64'sd8388608;
		a = (num >= 0) ? (num + 22) / 45 : -((-num + 22) / 45);
		u = a[31:0];
		flip = (u[31:30] == 2'd1) || (u[31:30] == 2'd2);
		if (flip) u = u + 32'h8000_0000;
		z = longint'($signed(u));
		x = longint'(CORDIC_GAIN);
		y = 0;
		for (int i = 0; i < TRIG_ITERATIONS; i++) begin
			dx = fshift(y, i % 32);
			dy = fshift(x, i % 32);
			if (z >= 0) begin
				x = x - dx; y = y + dy; z = z - longint'(ATAN_BAM[i % 32]);
			end else begin
				x = x + dx; y = y - dy; z = z + longint'(ATAN_BAM[i % 32]);
			end
		end
		if (flip) begin
			x = -x; y = -y;
		end
		c = x;
		s = y;
	endfunction

	static function longint triple(longint p, longint q, longint r);
		return fshift(p * q + (64'sd1 <<< 29), 30) * r;
	endfunction

	// Q60 sum to output format with saturation at +/- one
	static function entry_t to_entry(longint v);
		longint one, r;
		one = 64'sd1 <<< OUT_FRAC_BITS;
		r = fshift(v + (64'sd1 <<< (60 - OUT_FRAC_BITS - 1)), 60 - OUT_FRAC_BITS);
		if (r > one) r = one;
		if (r < -one) r = -one;
		return r[15:0];
	endfunction

	function void note_angles(angle_t ax, angle_t ay, angle_t az);
		longint sg, cg, sb, cb, sa, ca;
		rot_matrix_t e;
		sin_cos(ax, sg, cg);
		sin_cos(ay, sb, cb);
		sin_cos(az, sa, ca);
		e.m[0] = to_entry(ca * cb);
		e.m[1] = to_entry(triple(ca, sb, sg) - sa * cg);
		e.m[2] = to_entry(triple(ca, sb, cg) + sa * sg);
		e.m[3] = to_entry(sa * cb);
		e.m[4] = to_entry(triple(sa, sb, sg) + ca * cg);
		e.m[5] = to_entry(triple(sa, sb, cg) - ca * sg);
		e.m[6] = to_entry(-(sb * (64'sd1 <<< 30)));
		e.m[7] = to_entry(cb * sg);
		e.m[8] = to_entry(cb * cg);
		pending.push_back(e);
	endfunction

	task report(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	task check_matrix(rot_matrix_t got);
		rot_matrix_t e;
		if (pending.size() == 0) begin
			report("matrix beat with nothing pending");
			return;
		end
		e = pending.pop_front();
		for (int k = 0; k < 9; k++)
			if (got.m[k] !== e.m[k])
				report($sformatf("m%0d%0d got %0d want %0d", k / 3, k % 3,
					got.m[k], e.m[k]));
	endtask
endclass

module tb_rpy_angles_to_rotation_matrix;
	logic clk;
	logic arst_n;

	rpy_in_if  angles ();
	rpy_out_if matrix ();

	rpy_angles_to_rotation_matrix u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.angles (angles.sink),
		.matrix (matrix.source)
	);

	rotation_scoreboard sb;

	// idle percentages for sender and receiver, changed per phase
	int send_idle_pct;
	int recv_stall_pct;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// generous limit for ~2000 beats under random sender idles and receiver stalls
	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// receiver: random ready, check every accepted matrix beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix.ready <= 1'b0;
		end else begin
			if (matrix.valid && matrix.ready) begin
				rot_matrix_t got;
				got.m = '{matrix.m00, matrix.m01, matrix.m02, matrix.m10, matrix.m11,
					matrix.m12, matrix.m20, matrix.m21, matrix.m22};
				sb.check_matrix(got);
			end
			matrix.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// one angle beat; valid stays high across back-to-back beats
	task automatic send_angles(angle_t ax, angle_t ay, angle_t az);
		while ($urandom_range(99) < send_idle_pct) begin
			angles.valid <= 1'b0;
			@(posedge clk);
		end
		angles.valid   <= 1'b1;
		angles.angle_x <= ax;
		angles.angle_y <= ay;
		angles.angle_z <= az;
		do @(posedge clk); while (!angles.ready);
		sb.note_angles(ax, ay, az);
	endtask

	// mostly in-range angles, a few raw 15-bit patterns to exercise wrapping
	function automatic angle_t pick_angle();
		int r;
		r = $urandom_range(99);
		if (r < 80) return angle_t'($urandom_range(23040) - 11520);
		if (r < 90) return angle_t'(($urandom_range(8) - 4) * 2880 + $urandom_range(2) - 1);
		return angle_t'($urandom);
	endfunction

	task automatic run_phase(int idle, int stall, int n);
		send_idle_pct  = idle;
		recv_stall_pct = stall;
		repeat (n) send_angles(pick_angle(), pick_angle(), pick_angle());
	endtask

	initial begin
		angle_t dir [$];
		sb = new();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		angles.valid   <= 1'b0;
		angles.angle_x <= '0;
		angles.angle_y <= '0;
		angles.angle_z <= '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero, quadrant edges, range ends, full 15-bit extremes
		dir = '{15'sd0, 15'sd5760, -15'sd5760, 15'sd11520, -15'sd11520, 15'sd2880,
			15'sd16383, -15'sd16384, 15'sd1, -15'sd1, 15'sd11519, 15'sd8640};
		foreach (dir[i]) send_angles(dir[i], dir[(i + 3) % dir.size()],
			dir[(i + 7) % dir.size()]);
		// pitch at +/-90 gives gimbal lock, rounding close to saturation
		send_angles(15'sd2880, 15'sd5760, -15'sd2880);
		send_angles(-15'sd8000, -15'sd5760, 15'sd3000);
		send_angles(15'sd16383, 15'sd16383, 15'sd16383);
		send_angles(-15'sd16384, -15'sd16384, -15'sd16384);

		run_phase(0, 0, 440);
		run_phase(52, 0, 440);
		run_phase(0, 52, 440);
		run_phase(19, 19, 430);
		angles.valid <= 1'b0;

		// drain, then let the pipeline settle
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (TRIG_ITERATIONS + 20) @(posedge clk);

		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
